### rtl/e2q_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// e2q_pkg: shared constants and types for the Euler-to-quaternion core
// Q30 angle constants, CORDIC arctangent table, field and datapath widths.
// ----------------------------------------------------------------------------
package e2q_pkg;

    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int QUAT_FRAC_BITS_DEF  = 14;

    localparam int FIELD_W    = 16;
    localparam int NUM_LANES  = 3;
    localparam int NUM_QUAT   = 4;
    localparam int IN_DATA_W  = NUM_LANES * FIELD_W;
    localparam int OUT_DATA_W = NUM_QUAT * FIELD_W;

    localparam int LANE_ROLL  = 0;
    localparam int LANE_PITCH = 1;
    localparam int LANE_YAW   = 2;

    localparam int Q30_FRAC     = 30;
    localparam int CORDIC_STEPS = 30;

    localparam int ANG_W  = 33;
    localparam int XY_W   = 33;
    localparam int TRIG_W = 32;
    localparam int PROD_W = 2 * TRIG_W;
    localparam int SUM_W  = TRIG_W + 1;

    typedef logic signed [ANG_W-1:0]  t_ang;
    typedef logic signed [XY_W-1:0]   t_xy;
    typedef logic signed [TRIG_W-1:0] t_trig;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_sum;

    // Q30 constants, unsigned for magnitude reduction, signed for folding
    localparam logic [ANG_W-1:0] Q30_TWO_PI_U = 33'd6746518852;
    localparam logic [ANG_W-1:0] Q30_PI_U     = 33'd3373259426;
    localparam t_ang ANG_PI      = 33'sd3373259426;
    localparam t_ang ANG_HALF_PI = 33'sd1686629713;

    localparam t_xy CORDIC_GAIN = 33'sd652032874;

    // arctan(2^-i) in Q30, truncated
    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
    };

endpackage
`default_nettype wire

### rtl/euler_to_quaternion_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// euler_to_quaternion_core: roll/pitch/yaw to unit quaternion (ZYX order)
// Fully pipelined: three angle lanes, a 30-stage CORDIC per lane and a
// two-level registered product tree, ending in round and saturate.
// ----------------------------------------------------------------------------
// Usage
//   Slave channel: one word carries roll, pitch and yaw in radians, signed,
//   ANGLE_FRAC_BITS fraction bits. Master channel: one word carries the
//   quaternion w, x, y, z, signed, QUAT_FRAC_BITS fraction bits, saturated
//   to +/-1.0 (and to +/-32767 where 1.0 does not fit the field).
//   Throughput: one word per clock while the skid register is empty. Every
//   stage is a register stage under one shared advance enable, so a new word
//   enters each cycle unless a stall holds it. The pipeline depth is set by
//   the 30 CORDIC iteration stages, plus range reduction ahead of them and
//   the product, round and saturate stages after.
//   Reset (synchronous, active low) drops every word in flight; no other
//   state exists, as each word is independent of the ones before it.
//   Receiver stall: the output register holds its word and a one-word skid
//   register catches the next one. Once the skid is full the whole pipeline
//   holds and o_s_axis_tready goes low; it is a registered signal, so the
//   two channels never form a combinational path.
// ----------------------------------------------------------------------------
module euler_to_quaternion_core #(
    parameter int ANGLE_FRAC_BITS = e2q_pkg::ANGLE_FRAC_BITS_DEF,
    parameter int QUAT_FRAC_BITS  = e2q_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // roll_angle [15:0], pitch_angle [31:16], yaw_angle [47:32]
    input  logic [e2q_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // quat_w [15:0], quat_x [31:16], quat_y [47:32], quat_z [63:48]
    output logic [e2q_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import e2q_pkg::*;

    // ------------------------------------------------------------------
    // Derived constants
    // ------------------------------------------------------------------
    // half angle in Q30 = input << HALF_SHIFT
    localparam int HALF_SHIFT = Q30_FRAC - 1 - ANGLE_FRAC_BITS;
    localparam int MAG_W      = FIELD_W + HALF_SHIFT;
    localparam int RED_W      = (MAG_W > ANG_W) ? MAG_W : ANG_W;
    // multiples of 2*pi to strip: quotient bits of |half angle| / (2*pi)
    localparam int RED_STEPS  = (HALF_SHIFT > 18) ? HALF_SHIFT - 17 : 1;
    localparam int RED_LO     = (RED_STEPS < 2) ? RED_STEPS : 2;
    localparam logic [RED_W-1:0] TWO_PI_R = RED_W'(Q30_TWO_PI_U);

    localparam int OUT_SHIFT = Q30_FRAC - QUAT_FRAC_BITS;
    localparam int OUT_RND   = (1 << OUT_SHIFT) >> 1;
    localparam int OUT_LIM   = (QUAT_FRAC_BITS >= FIELD_W - 1) ?
                               (1 << (FIELD_W - 1)) - 1 : (1 << QUAT_FRAC_BITS);
    localparam t_sum OUT_RND_S = t_sum'(OUT_RND);
    localparam t_sum LIM_POS   = t_sum'(OUT_LIM);
    localparam t_sum LIM_NEG   = -LIM_POS;
    localparam logic signed [FIELD_W-1:0] LIM_POS16 = FIELD_W'(OUT_LIM);
    localparam logic signed [FIELD_W-1:0] LIM_NEG16 = -LIM_POS16;

    localparam t_prod RND30 = t_prod'(1) <<< (Q30_FRAC - 1);

    // stage positions
    localparam int ST_ABS    = 0;
    localparam int ST_RED_HI = 1;
    localparam int ST_RED_LO = 2;
    localparam int ST_WRAP   = 3;
    localparam int ST_SIGN   = 4;
    localparam int ST_FOLD   = 5;
    localparam int ST_CS     = ST_FOLD + CORDIC_STEPS + 1;
    localparam int ST_MUL1   = ST_CS + 1;
    localparam int ST_RND1   = ST_MUL1 + 1;
    localparam int ST_MUL2   = ST_RND1 + 1;
    localparam int ST_RND2   = ST_MUL2 + 1;
    localparam int ST_SUM    = ST_RND2 + 1;
    localparam int ST_SCALE  = ST_SUM + 1;
    localparam int ST_SAT    = ST_SCALE + 1;
    localparam int N_STAGES  = ST_SAT + 1;

    // first-level products
    localparam int P_CYCP = 0;
    localparam int P_SYSP = 1;
    localparam int P_SYCP = 2;
    localparam int P_CYSP = 3;
    localparam int NUM_P1 = 4;
    localparam int NUM_P2 = 8;

    localparam int Q_W = 0;
    localparam int Q_X = 1;
    localparam int Q_Y = 2;
    localparam int Q_Z = 3;

    function automatic t_trig rnd30(input t_prod p);
        t_prod t;
        t = (p + RND30) >>> Q30_FRAC;
        return t_trig'(t);
    endfunction

    // ------------------------------------------------------------------
    // Pipeline control: one advance enable for every stage
    // ------------------------------------------------------------------
    logic                  en;
    logic [N_STAGES-1:0]   r_vld;
    logic                  r_out_vld;
    logic                  r_skid_vld;

    assign en              = !r_skid_vld;
    assign o_s_axis_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[N_STAGES-2:0], i_s_axis_tvalid};
        end
    end

    // ------------------------------------------------------------------
    // Stage registers
    // ------------------------------------------------------------------
    logic [FIELD_W-1:0]   r_mag      [NUM_LANES];
    logic [NUM_LANES-1:0] r_sgn      [ST_SIGN];
    logic [RED_W-1:0]     r_red_hi   [NUM_LANES];
    logic [ANG_W-1:0]     r_red_lo   [NUM_LANES];
    t_ang                 r_wrap     [NUM_LANES];
    t_ang                 r_sgnd     [NUM_LANES];
    t_ang                 r_fold_z   [NUM_LANES];
    logic [NUM_LANES-1:0] r_fold_neg;
    t_xy                  r_cx       [CORDIC_STEPS][NUM_LANES];
    t_xy                  r_cy       [CORDIC_STEPS][NUM_LANES];
    t_ang                 r_cz       [CORDIC_STEPS][NUM_LANES];
    logic [NUM_LANES-1:0] r_cneg     [CORDIC_STEPS];
    t_trig                r_cos      [NUM_LANES];
    t_trig                r_sin      [NUM_LANES];
    t_prod                r_p1       [NUM_P1];
    t_trig                r_cr1, r_sr1, r_cr2, r_sr2;
    t_trig                r_q1       [NUM_P1];
    t_prod                r_p2       [NUM_P2];
    t_trig                r_q2       [NUM_P2];
    t_sum                 r_sum      [NUM_QUAT];
    t_sum                 r_scl      [NUM_QUAT];
    logic [FIELD_W-1:0]   r_quat     [NUM_QUAT];

    logic [FIELD_W-1:0]   n_mag      [NUM_LANES];
    logic [NUM_LANES-1:0] n_sgn;
    logic [RED_W-1:0]     n_red_hi   [NUM_LANES];
    logic [ANG_W-1:0]     n_red_lo   [NUM_LANES];
    t_ang                 n_wrap     [NUM_LANES];
    t_ang                 n_sgnd     [NUM_LANES];
    t_ang                 n_fold_z   [NUM_LANES];
    logic [NUM_LANES-1:0] n_fold_neg;
    t_xy                  n_cx       [CORDIC_STEPS][NUM_LANES];
    t_xy                  n_cy       [CORDIC_STEPS][NUM_LANES];
    t_ang                 n_cz       [CORDIC_STEPS][NUM_LANES];
    t_trig                n_cos      [NUM_LANES];
    t_trig                n_sin      [NUM_LANES];
    t_prod                n_p1       [NUM_P1];
    t_trig                n_q1       [NUM_P1];
    t_prod                n_p2       [NUM_P2];
    t_trig                n_q2       [NUM_P2];
    t_sum                 n_sum      [NUM_QUAT];
    t_sum                 n_scl      [NUM_QUAT];
    logic [FIELD_W-1:0]   n_quat     [NUM_QUAT];

    // CORDIC iteration inputs
    t_xy                  c_xin      [CORDIC_STEPS][NUM_LANES];
    t_xy                  c_yin      [CORDIC_STEPS][NUM_LANES];
    t_ang                 c_zin      [CORDIC_STEPS][NUM_LANES];

    // ------------------------------------------------------------------
    // Range reduction: |half angle| mod 2*pi, wrap to (-pi, pi], restore
    // sign, then fold into [-pi/2, pi/2] with a negate flag
    // ------------------------------------------------------------------
    always_comb begin
        logic [FIELD_W-1:0] raw;
        logic [RED_W-1:0]   a;
        logic [RED_W-1:0]   b;
        for (int l = 0; l < NUM_LANES; l++) begin
            // take magnitude and sign of the raw angle
            raw       = i_s_axis_tdata[l*FIELD_W +: FIELD_W];
            n_sgn[l]  = raw[FIELD_W-1];
            n_mag[l]  = raw[FIELD_W-1] ? (FIELD_W'(0) - raw) : raw;

            // strip the large multiples of 2*pi
            a = RED_W'(r_mag[l]) << HALF_SHIFT;
            for (int k = RED_STEPS - 1; k >= 2; k--) begin
                if (a >= (TWO_PI_R << k)) begin
                    a = a - (TWO_PI_R << k);
                end
            end
            n_red_hi[l] = a;

            // strip the last two
            b = r_red_hi[l];
            for (int k = RED_LO - 1; k >= 0; k--) begin
                if (b >= (TWO_PI_R << k)) begin
                    b = b - (TWO_PI_R << k);
                end
            end
            n_red_lo[l] = ANG_W'(b);

            n_wrap[l] = (r_red_lo[l] > Q30_PI_U) ? t_ang'(r_red_lo[l] - Q30_TWO_PI_U)
                                                 : t_ang'(r_red_lo[l]);

            n_sgnd[l] = r_sgn[ST_SIGN-1][l] ? -r_wrap[l] : r_wrap[l];

            if (r_sgnd[l] > ANG_HALF_PI) begin
                n_fold_z[l]   = r_sgnd[l] - ANG_PI;
                n_fold_neg[l] = 1'b1;
            end else if (r_sgnd[l] < -ANG_HALF_PI) begin
                n_fold_z[l]   = r_sgnd[l] + ANG_PI;
                n_fold_neg[l] = 1'b1;
            end else begin
                n_fold_z[l]   = r_sgnd[l];
                n_fold_neg[l] = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // CORDIC, rotation mode: one iteration per stage, shift fixed per stage
    // ------------------------------------------------------------------
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            c_xin[0][l] = CORDIC_GAIN;
            c_yin[0][l] = '0;
            c_zin[0][l] = r_fold_z[l];
        end
        for (int j = 1; j < CORDIC_STEPS; j++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                c_xin[j][l] = r_cx[j-1][l];
                c_yin[j][l] = r_cy[j-1][l];
                c_zin[j][l] = r_cz[j-1][l];
            end
        end
        for (int j = 0; j < CORDIC_STEPS; j++) begin
            for (int l = 0; l < NUM_LANES; l++) begin
                if (c_zin[j][l] >= 0) begin
                    n_cx[j][l] = c_xin[j][l] - (c_yin[j][l] >>> j);
                    n_cy[j][l] = c_yin[j][l] + (c_xin[j][l] >>> j);
                    n_cz[j][l] = c_zin[j][l] - t_ang'(ATAN_TAB[j]);
                end else begin
                    n_cx[j][l] = c_xin[j][l] + (c_yin[j][l] >>> j);
                    n_cy[j][l] = c_yin[j][l] - (c_xin[j][l] >>> j);
                    n_cz[j][l] = c_zin[j][l] + t_ang'(ATAN_TAB[j]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Undo the fold, then the ZYX product tree, round and saturate
    // ------------------------------------------------------------------
    always_comb begin
        for (int l = 0; l < NUM_LANES; l++) begin
            n_cos[l] = t_trig'(r_cneg[CORDIC_STEPS-1][l] ? -r_cx[CORDIC_STEPS-1][l]
                                                         : r_cx[CORDIC_STEPS-1][l]);
            n_sin[l] = t_trig'(r_cneg[CORDIC_STEPS-1][l] ? -r_cy[CORDIC_STEPS-1][l]
                                                         : r_cy[CORDIC_STEPS-1][l]);
        end

        n_p1[P_CYCP] = t_prod'(r_cos[LANE_YAW]) * t_prod'(r_cos[LANE_PITCH]);
        n_p1[P_SYSP] = t_prod'(r_sin[LANE_YAW]) * t_prod'(r_sin[LANE_PITCH]);
        n_p1[P_SYCP] = t_prod'(r_sin[LANE_YAW]) * t_prod'(r_cos[LANE_PITCH]);
        n_p1[P_CYSP] = t_prod'(r_cos[LANE_YAW]) * t_prod'(r_sin[LANE_PITCH]);

        for (int k = 0; k < NUM_P1; k++) begin
            n_q1[k] = rnd30(r_p1[k]);
        end

        n_p2[0] = t_prod'(r_q1[P_CYCP]) * t_prod'(r_cr2);
        n_p2[1] = t_prod'(r_q1[P_SYSP]) * t_prod'(r_sr2);
        n_p2[2] = t_prod'(r_q1[P_CYCP]) * t_prod'(r_sr2);
        n_p2[3] = t_prod'(r_q1[P_SYSP]) * t_prod'(r_cr2);
        n_p2[4] = t_prod'(r_q1[P_SYCP]) * t_prod'(r_sr2);
        n_p2[5] = t_prod'(r_q1[P_CYSP]) * t_prod'(r_cr2);
        n_p2[6] = t_prod'(r_q1[P_SYCP]) * t_prod'(r_cr2);
        n_p2[7] = t_prod'(r_q1[P_CYSP]) * t_prod'(r_sr2);

        for (int k = 0; k < NUM_P2; k++) begin
            n_q2[k] = rnd30(r_p2[k]);
        end

        n_sum[Q_W] = t_sum'(r_q2[0]) + t_sum'(r_q2[1]);
        n_sum[Q_X] = t_sum'(r_q2[2]) - t_sum'(r_q2[3]);
        n_sum[Q_Y] = t_sum'(r_q2[4]) + t_sum'(r_q2[5]);
        n_sum[Q_Z] = t_sum'(r_q2[6]) - t_sum'(r_q2[7]);

        for (int k = 0; k < NUM_QUAT; k++) begin
            n_scl[k] = (r_sum[k] + OUT_RND_S) >>> OUT_SHIFT;
            if (r_scl[k] > LIM_POS) begin
                n_quat[k] = LIM_POS[FIELD_W-1:0];
            end else if (r_scl[k] < LIM_NEG) begin
                n_quat[k] = LIM_NEG[FIELD_W-1:0];
            end else begin
                n_quat[k] = r_scl[k][FIELD_W-1:0];
            end
        end
    end

    // payload: hold everything while the skid register is full
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag      <= n_mag;
            r_sgn[0]   <= n_sgn;
            for (int s = 1; s < ST_SIGN; s++) begin
                r_sgn[s] <= r_sgn[s-1];
            end
            r_red_hi   <= n_red_hi;
            r_red_lo   <= n_red_lo;
            r_wrap     <= n_wrap;
            r_sgnd     <= n_sgnd;
            r_fold_z   <= n_fold_z;
            r_fold_neg <= n_fold_neg;
            r_cx       <= n_cx;
            r_cy       <= n_cy;
            r_cz       <= n_cz;
            r_cneg[0]  <= r_fold_neg;
            for (int j = 1; j < CORDIC_STEPS; j++) begin
                r_cneg[j] <= r_cneg[j-1];
            end
            r_cos      <= n_cos;
            r_sin      <= n_sin;
            r_p1       <= n_p1;
            r_cr1      <= r_cos[LANE_ROLL];
            r_sr1      <= r_sin[LANE_ROLL];
            r_q1       <= n_q1;
            r_cr2      <= r_cr1;
            r_sr2      <= r_sr1;
            r_p2       <= n_p2;
            r_q2       <= n_q2;
            r_sum      <= n_sum;
            r_scl      <= n_scl;
            r_quat     <= n_quat;
        end
    end

    // ------------------------------------------------------------------
    // Output register and skid word
    // ------------------------------------------------------------------
    logic [OUT_DATA_W-1:0] last_data;
    logic [OUT_DATA_W-1:0] r_out;
    logic [OUT_DATA_W-1:0] r_skid;

    always_comb begin
        for (int k = 0; k < NUM_QUAT; k++) begin
            last_data[k*FIELD_W +: FIELD_W] = r_quat[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            // drain the skid word once the output word is taken
            if (i_m_axis_tready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (!r_out_vld || i_m_axis_tready) begin
            r_out_vld <= r_vld[N_STAGES-1];
        end else if (r_vld[N_STAGES-1]) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_m_axis_tready) begin
                r_out <= r_skid;
            end
        end else if (!r_out_vld || i_m_axis_tready) begin
            r_out <= last_data;
        end else begin
            r_skid <= last_data;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic fold_ok;
    logic out_ok;

    always_comb begin
        fold_ok = 1'b1;
        for (int l = 0; l < NUM_LANES; l++) begin
            if (r_fold_z[l] > ANG_HALF_PI || r_fold_z[l] < -ANG_HALF_PI) begin
                fold_ok = 1'b0;
            end
        end
        out_ok = 1'b1;
        for (int k = 0; k < NUM_QUAT; k++) begin
            if ($signed(r_out[k*FIELD_W +: FIELD_W]) > LIM_POS16 ||
                $signed(r_out[k*FIELD_W +: FIELD_W]) < LIM_NEG16) begin
                out_ok = 1'b0;
            end
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid word held without an output word");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_vld) |-> $past(r_out_vld && !i_m_axis_tready))
        else $error("skid word filled while the output was free");

    a_fold_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_FOLD] |-> fold_ok)
        else $error("folded half angle outside +/- pi/2");

    a_out_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> out_ok)
        else $error("quaternion component beyond saturation limit");

endmodule
`default_nettype wire

### test/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for euler_to_quaternion_core
// Streams roll/pitch/yaw words into the core under several idle and stall
// patterns, predicts each quaternion with an independent CORDIC model and
// checks every output word, field by field, in arrival order.
// ----------------------------------------------------------------------------
module tb;

    import e2q_pkg::*;

    localparam int  ANGLE_FRAC   = ANGLE_FRAC_BITS_DEF;
    localparam int  QUAT_FRAC    = QUAT_FRAC_BITS_DEF;
    localparam int  TRIG_STEPS   = 30;
    localparam int  RANDOM_WORDS = 195;
    localparam int  DRAIN_CYCLES = 60;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  REPORT_MAX   = 10;

    localparam longint HALF_TURN_Q30 = 64'sd3373259426;
    localparam longint FULL_TURN_Q30 = 64'sd6746518852;
    localparam longint QUARTER_Q30   = 64'sd1686629713;
    localparam longint GAIN_Q30      = 64'sd652032874;

    // arctan(2^-i), Q30, truncated
    localparam longint ARCTAN_Q30 [TRIG_STEPS] = '{
        'h3243F6A8, 'h1DAC6705, 'h0FADBAFC, 'h07F56EA6, 'h03FEAB76, 'h01FFD55B,
        'h00FFFAAA, 'h007FFF55, 'h003FFFEA, 'h001FFFFD, 'h000FFFFF, 'h0007FFFF,
        'h0003FFFF, 'h0001FFFF, 'h0000FFFF, 'h00007FFF, 'h00003FFF, 'h00001FFF,
        'h00000FFF, 'h000007FF, 'h000003FF, 'h000001FF, 'h000000FF, 'h0000007F,
        'h0000003F, 'h0000001F, 'h0000000F, 'h00000008, 'h00000004, 'h00000002
    };

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata  = '0;
    logic                  i_m_axis_tready = 1'b0;
    logic                  o_s_axis_tready;
    logic                  o_m_axis_tvalid;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    euler_to_quaternion_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    class quat_scoreboard;
        logic [OUT_DATA_W-1:0] expected_quats [$];
        int                    mismatch_count;

        function new();
            mismatch_count = 0;
        endfunction

        function longint floor_shift(longint v, int s);
            return v >>> s;
        endfunction

        function longint mul_round_q30(longint a, longint b);
            return (a * b + (64'sd1 <<< 29)) >>> 30;
        endfunction

        // cosine and sine of half the angle, both Q30
        function void half_angle_trig(logic signed [15:0] angle,
                                      output longint c, output longint s);
            longint h;
            longint x;
            longint y;
            longint dx;
            longint dy;
            bit     flip;
            h    = longint'(angle) * (64'sd1 <<< (29 - ANGLE_FRAC));
            x    = GAIN_Q30;
            y    = 0;
            flip = 1'b0;
            h    = h % FULL_TURN_Q30;
            if (h > HALF_TURN_Q30) h = h - FULL_TURN_Q30;
            if (h < -HALF_TURN_Q30) h = h + FULL_TURN_Q30;
            // fold into the right half plane, negate the pair afterwards
            if (h > QUARTER_Q30) begin
                h    = h - HALF_TURN_Q30;
                flip = 1'b1;
            end else if (h < -QUARTER_Q30) begin
                h    = h + HALF_TURN_Q30;
                flip = 1'b1;
            end
            for (int i = 0; i < TRIG_STEPS; i++) begin
                dx = floor_shift(y, i);
                dy = floor_shift(x, i);
                if (h >= 0) begin
                    x = x - dx;
                    y = y + dy;
                    h = h - ARCTAN_Q30[i];
                end else begin
                    x = x + dx;
                    y = y - dy;
                    h = h + ARCTAN_Q30[i];
                end
            end
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic [15:0] round_to_quat(longint v);
            longint bound;
            int     sh;
            bound = 64'sd1 <<< QUAT_FRAC;
            sh    = 30 - QUAT_FRAC;
            if (sh > 0) v = (v + (64'sd1 <<< (sh - 1))) >>> sh;
            if (bound > 32767) bound = 32767;
            if (v > bound) v = bound;
            if (v < -bound) v = -bound;
            return v[15:0];
        endfunction

        function void note_angles(logic [IN_DATA_W-1:0] word);
            longint cr, sr, cp, sp, cy, sy;
            longint cycp, sysp, sycp, cysp;
            logic [15:0] qw, qx, qy, qz;
            half_angle_trig(word[15:0], cr, sr);
            half_angle_trig(word[31:16], cp, sp);
            half_angle_trig(word[47:32], cy, sy);
            cycp = mul_round_q30(cy, cp);
            sysp = mul_round_q30(sy, sp);
            sycp = mul_round_q30(sy, cp);
            cysp = mul_round_q30(cy, sp);
            qw = round_to_quat(mul_round_q30(cycp, cr) + mul_round_q30(sysp, sr));
            qx = round_to_quat(mul_round_q30(cycp, sr) - mul_round_q30(sysp, cr));
            qy = round_to_quat(mul_round_q30(sycp, sr) + mul_round_q30(cysp, cr));
            qz = round_to_quat(mul_round_q30(sycp, cr) - mul_round_q30(cysp, sr));
            expected_quats.push_back({qz, qy, qx, qw});
        endfunction

        function void check_quat(logic [OUT_DATA_W-1:0] word);
            logic [OUT_DATA_W-1:0] want;
            string                 names [NUM_QUAT];
            names = '{"w", "x", "y", "z"};
            if (expected_quats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected quaternion word %h", word);
                return;
            end
            want = expected_quats.pop_front();
            for (int f = 0; f < NUM_QUAT; f++) begin
                if (word[f*FIELD_W +: FIELD_W] !== want[f*FIELD_W +: FIELD_W]) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("quat_%s mismatch: expected %0d, got %0d", names[f],
                                 $signed(want[f*FIELD_W +: FIELD_W]),
                                 $signed(word[f*FIELD_W +: FIELD_W]));
                end
            end
        endfunction
    endclass

    quat_scoreboard        sb = new();
    logic [IN_DATA_W-1:0]  angle_words [$];
    int                    queued_count   = 0;
    int                    accepted_count = 0;
    int                    send_idle_pct  = 0;
    int                    recv_stall_pct = 0;
    int                    cycle_count    = 0;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // sender: hold the word until taken, then advance or idle
    initial begin
        bit taken;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            taken = i_s_axis_tvalid && o_s_axis_tready;
            if (taken) begin
                sb.note_angles(i_s_axis_tdata);
                accepted_count++;
            end
            if (!i_s_axis_tvalid || taken) begin
                if (angle_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_s_axis_tdata  <= angle_words.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: check each taken word, stall at random
    initial begin
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_quat(o_m_axis_tdata);
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic queue_angles(input logic [15:0] roll, input logic [15:0] pitch,
                                input logic [15:0] yaw);
        angle_words.push_back({yaw, pitch, roll});
        queued_count++;
    endtask

    // mostly legal angles, some near the fold points, some raw 16-bit values
    function automatic logic [15:0] pick_angle();
        int          base;
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'($urandom);
            1: begin
                case ($urandom_range(0, 2))
                    0:       base = 0;
                    1:       base = 12868;
                    default: base = 25736;
                endcase
                base = base + $urandom_range(0, 8) - 4;
                if ($urandom_range(0, 1)) base = -base;
                v = base[15:0];
            end
            default: begin
                base = $urandom_range(0, 51472) - 25736;
                v    = base[15:0];
            end
        endcase
        return v;
    endfunction

    task automatic wait_accepted();
        while (accepted_count != queued_count) @(posedge i_clk);
    endtask

    task automatic run_random(input int idle_pct, input int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < RANDOM_WORDS; n++)
            queue_angles(pick_angle(), pick_angle(), pick_angle());
        wait_accepted();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (i_rst_n);

        // directed: zero, range ends, field ends, half-angle fold boundary
        queue_angles(16'sd0, 16'sd0, 16'sd0);
        queue_angles(16'sd25736, 16'sd25736, 16'sd25736);
        queue_angles(-16'sd25736, -16'sd25736, -16'sd25736);
        queue_angles(16'sd25735, -16'sd25735, 16'sd25735);
        queue_angles(16'sd32767, 16'sd32767, 16'sd32767);
        queue_angles(16'h8000, 16'h8000, 16'h8000);
        queue_angles(16'sd32767, 16'h8000, 16'sd0);
        queue_angles(16'sd12868, 16'sd0, 16'sd0);
        queue_angles(16'sd0, 16'sd12868, 16'sd0);
        queue_angles(16'sd0, 16'sd0, 16'sd12868);
        queue_angles(16'sd0, -16'sd12868, 16'sd0);
        queue_angles(16'sd5000, 16'sd12868, -16'sd7000);
        queue_angles(16'sd1, -16'sd1, 16'sd1);
        queue_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_angles(16'sd25736, 16'sd0, 16'sd0);
        queue_angles(16'sd0, 16'sd25736, 16'sd0);
        queue_angles(16'sd0, 16'sd0, -16'sd25736);
        queue_angles(16'h5555, 16'hAAAA, 16'h5555);
        queue_angles(16'hAAAA, 16'h5555, 16'hAAAA);
        queue_angles(16'sd8580, -16'sd17160, 16'sd21000);
        wait_accepted();

        run_random(0, 0);
        run_random(48, 0);
        run_random(0, 48);
        run_random(31, 31);

        while (sb.expected_quats.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.mismatch_count == 0 && sb.expected_quats.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
